// File: rtl/learning_switch_table_with_aging_assert.svh
`ifndef LEARNING_SWITCH_TABLE_WITH_AGING_ASSERT_SVH
`define LEARNING_SWITCH_TABLE_WITH_AGING_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LSTA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent starts in the next cycle
`define LSTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lsta_pkg.sv
package lsta_pkg;

    localparam int ST_W = 5;
    localparam int PT_W = 3;
    localparam int AG_W = 8;

    localparam logic [AG_W-1:0] AGING_RESET = 8'd10;

    localparam logic MODE_FRAME = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    localparam logic KIND_FWD = 1'b0;
    localparam logic KIND_EXP = 1'b1;

    localparam logic [0:0] REG_AGING_START = 1'b0;

    typedef struct packed {
        logic            learn;
        logic [ST_W-1:0] src;
        logic [ST_W-1:0] dst;
        logic [PT_W-1:0] port;
        logic [AG_W-1:0] aging;
    } cell_ctl_t;

    typedef struct packed {
        logic            hit;
        logic [PT_W-1:0] port;
        logic            expire;
    } cell_stat_t;

endpackage

// File: rtl/lsta_cell.sv
module lsta_cell #(
    parameter int IDX = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tok_in,
    input  lsta_pkg::cell_ctl_t   ctl,
    output logic                  tok_out,
    output lsta_pkg::cell_stat_t  stat
);

    logic                        tok_reg;
    logic                        valid_reg;
    logic                        valid_next;
    logic [lsta_pkg::PT_W-1:0]   port_reg;
    logic [lsta_pkg::AG_W-1:0]   timer_reg;
    logic [lsta_pkg::AG_W-1:0]   timer_next;
    logic                        learn_here;
    logic                        age_out;

    assign learn_here = ctl.learn && (int'(ctl.src) == IDX);
    assign age_out    = tok_reg && valid_reg && (timer_reg <= 8'd1);

    always_comb
    begin
        valid_next = valid_reg;
        timer_next = timer_reg;
        if (learn_here)
        begin
            valid_next = 1'b1;
            timer_next = ctl.aging;
        end
        else if (tok_reg && valid_reg)
        begin
            if (age_out)
            begin
                valid_next = 1'b0;
                timer_next = '0;
            end
            else
            begin
                timer_next = timer_reg - 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= 1'b0;
            valid_reg <= 1'b0;
            timer_reg <= '0;
        end
        else
        begin
            tok_reg   <= tok_in;
            valid_reg <= valid_next;
            timer_reg <= timer_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (learn_here)
        begin
            port_reg <= ctl.port;
        end
    end

    assign tok_out     = tok_reg;
    assign stat.hit    = valid_reg && (int'(ctl.dst) == IDX);
    assign stat.port   = port_reg;
    assign stat.expire = age_out;

endmodule

// File: rtl/learning_switch_table_with_aging.sv
// Channel   | Handshake            | Beat
// ----------+----------------------+---------------------------------------------
// command   | start, busy          | mode, src_station, dst_station, in_port
// result    | strobe (no stall)    | kind, port_mask, was_known, expired_station,
//           |                      | expired_port, last
// config    | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// A frame learns and looks up in state FRAME; the result shows in the next cycle.
// A tick passes a token down the row of STATIONS cells, one cell a cycle, so it
// stays busy until the token leaves the row, then in FLUSH if anything expired.
// Reset clears every valid bit and timer at once; no clearing pass.
// Results cannot be stalled; each beat shows for exactly one cycle.
module learning_switch_table_with_aging #(
    parameter int STATIONS = 32,
    parameter int PORTS    = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       mode,
    input  logic [lsta_pkg::ST_W-1:0]  src_station,
    input  logic [lsta_pkg::ST_W-1:0]  dst_station,
    input  logic [lsta_pkg::PT_W-1:0]  in_port,
    output logic                       strobe,
    output logic                       kind,
    output logic [PORTS-1:0]           port_mask,
    output logic                       was_known,
    output logic [lsta_pkg::ST_W-1:0]  expired_station,
    output logic [lsta_pkg::PT_W-1:0]  expired_port,
    output logic                       last,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [0:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FRAME = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [lsta_pkg::AG_W-1:0]   aging_reg;
    logic [lsta_pkg::ST_W-1:0]   src_reg;
    logic [lsta_pkg::ST_W-1:0]   dst_reg;
    logic [lsta_pkg::PT_W-1:0]   port_reg;

    logic                        accept;
    logic                        inject;

    logic                        pend_vld_reg;
    logic                        pend_vld_next;
    logic [lsta_pkg::ST_W-1:0]   pend_sta_reg;
    logic [lsta_pkg::ST_W-1:0]   pend_sta_next;
    logic [lsta_pkg::PT_W-1:0]   pend_port_reg;
    logic [lsta_pkg::PT_W-1:0]   pend_port_next;

    logic                        strobe_reg;
    logic                        strobe_next;
    logic                        kind_reg;
    logic                        kind_next;
    logic [PORTS-1:0]            mask_reg;
    logic [PORTS-1:0]            mask_next;
    logic                        known_reg;
    logic                        known_next;
    logic [lsta_pkg::ST_W-1:0]   esta_reg;
    logic [lsta_pkg::ST_W-1:0]   esta_next;
    logic [lsta_pkg::PT_W-1:0]   eport_reg;
    logic [lsta_pkg::PT_W-1:0]   eport_next;
    logic                        last_reg;
    logic                        last_next;

    lsta_pkg::cell_ctl_t         ctl;
    lsta_pkg::cell_stat_t        stat [STATIONS];
    logic [STATIONS:0]           tok;

    logic                        tbl_hit;
    logic [lsta_pkg::PT_W-1:0]   tbl_port;
    logic                        exp_any;
    logic [lsta_pkg::ST_W-1:0]   exp_sta;
    logic [lsta_pkg::PT_W-1:0]   exp_port;
    logic                        fwd_hit;
    logic                        known;
    logic [lsta_pkg::PT_W-1:0]   known_port;

    function automatic logic [PORTS-1:0] port_bit(input logic [lsta_pkg::PT_W-1:0] p);
        logic [PORTS-1:0] b;
        for (int k = 0; k < PORTS; k++)
        begin
            b[k] = (int'(p) == k);
        end
        return b;
    endfunction

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign inject = accept && (mode == lsta_pkg::MODE_TICK);

    // configuration
    assign pready = 1'b1;
    assign prdata = {{(32 - lsta_pkg::AG_W){1'b0}}, aging_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aging_reg <= lsta_pkg::AGING_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr == lsta_pkg::REG_AGING_START))
        begin
            aging_reg <= pwdata[lsta_pkg::AG_W-1:0];
        end
    end

    // hold the command beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_reg  <= src_station;
            dst_reg  <= dst_station;
            port_reg <= in_port;
        end
    end

    // row of cells
    assign ctl.learn = (state_reg == S_FRAME);
    assign ctl.src   = src_reg;
    assign ctl.dst   = dst_reg;
    assign ctl.port  = port_reg;
    assign ctl.aging = aging_reg;
    assign tok[0]    = inject;

    for (genvar g = 0; g < STATIONS; g++)
    begin : g_cell
        lsta_cell #(.IDX(g)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok[g]),
            .ctl     (ctl),
            .tok_out (tok[g+1]),
            .stat    (stat[g])
        );
    end

    always_comb
    begin
        tbl_hit  = 1'b0;
        tbl_port = '0;
        exp_any  = 1'b0;
        exp_sta  = '0;
        exp_port = '0;
        for (int i = 0; i < STATIONS; i++)
        begin
            tbl_hit  = tbl_hit | stat[i].hit;
            tbl_port = tbl_port | (stat[i].hit ? stat[i].port : '0);
            exp_any  = exp_any | stat[i].expire;
            exp_sta  = exp_sta | (stat[i].expire ? i[lsta_pkg::ST_W-1:0] : '0);
            exp_port = exp_port | (stat[i].expire ? stat[i].port : '0);
        end
    end

    // the source learned this cycle wins over the stored entry
    assign fwd_hit    = (dst_reg == src_reg) && (int'(src_reg) < STATIONS);
    assign known      = fwd_hit || tbl_hit;
    assign known_port = fwd_hit ? port_reg : tbl_port;

    always_comb
    begin
        state_next     = state_reg;
        pend_vld_next  = pend_vld_reg;
        pend_sta_next  = pend_sta_reg;
        pend_port_next = pend_port_reg;
        strobe_next    = 1'b0;
        kind_next      = kind_reg;
        mask_next      = mask_reg;
        known_next     = known_reg;
        esta_next      = esta_reg;
        eport_next     = eport_reg;
        last_next      = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = inject ? S_SWEEP : S_FRAME;
                end
            end
            S_FRAME:
            begin
                strobe_next = 1'b1;
                kind_next   = lsta_pkg::KIND_FWD;
                mask_next   = known ? port_bit(known_port) : ~port_bit(port_reg);
                known_next  = known;
                esta_next   = '0;
                eport_next  = '0;
                last_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_SWEEP:
            begin
                if (exp_any)
                begin
                    // release the previous report, hold the new one
                    if (pend_vld_reg)
                    begin
                        strobe_next = 1'b1;
                        kind_next   = lsta_pkg::KIND_EXP;
                        mask_next   = '0;
                        known_next  = 1'b0;
                        esta_next   = pend_sta_reg;
                        eport_next  = pend_port_reg;
                        last_next   = 1'b0;
                    end
                    pend_vld_next  = 1'b1;
                    pend_sta_next  = exp_sta;
                    pend_port_next = exp_port;
                end
                if (tok[STATIONS])
                begin
                    state_next = (pend_vld_reg || exp_any) ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH:
            begin
                strobe_next   = 1'b1;
                kind_next     = lsta_pkg::KIND_EXP;
                mask_next     = '0;
                known_next    = 1'b0;
                esta_next     = pend_sta_reg;
                eport_next    = pend_port_reg;
                last_next     = 1'b1;
                pend_vld_next = 1'b0;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pend_vld_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_vld_reg <= pend_vld_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_sta_reg  <= pend_sta_next;
        pend_port_reg <= pend_port_next;
        kind_reg      <= kind_next;
        mask_reg      <= mask_next;
        known_reg     <= known_next;
        esta_reg      <= esta_next;
        eport_reg     <= eport_next;
        last_reg      <= last_next;
    end

    assign strobe          = strobe_reg;
    assign kind            = kind_reg;
    assign port_mask       = mask_reg;
    assign was_known       = known_reg;
    assign expired_station = esta_reg;
    assign expired_port    = eport_reg;
    assign last            = last_reg;

endmodule

// File: rtl/lsta_checker.sv
`include "learning_switch_table_with_aging_assert.svh"

module lsta_checker #(
    parameter int PORTS = 8
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       mode,
    input logic                       strobe,
    input logic                       kind,
    input logic [PORTS-1:0]           port_mask,
    input logic                       was_known,
    input logic [lsta_pkg::ST_W-1:0]  expired_station,
    input logic [lsta_pkg::PT_W-1:0]  expired_port,
    input logic                       last
);

    `LSTA_ASSERT_NEXT(a_frame_beat, clk, rst_n,
        start && !busy && (mode == lsta_pkg::MODE_FRAME),
        busy ##1 (strobe && (kind == lsta_pkg::KIND_FWD) && last),
        "frame did not give one decision two cycles later")

    `LSTA_ASSERT_NOW(a_fwd_fields, clk, rst_n,
        strobe && (kind == lsta_pkg::KIND_FWD),
        (expired_station == '0) && (expired_port == '0) && last,
        "decision beat carries expiry fields")

    `LSTA_ASSERT_NOW(a_exp_fields, clk, rst_n,
        strobe && (kind == lsta_pkg::KIND_EXP),
        (port_mask == '0) && !was_known,
        "expiry beat carries forwarding fields")

    `LSTA_ASSERT_NEXT(a_last_frees, clk, rst_n,
        strobe && last,
        !strobe || (kind == lsta_pkg::KIND_FWD && $past(busy)) || !$past(busy),
        "beat after a final beat without a new command")

endmodule

bind learning_switch_table_with_aging lsta_checker #(.PORTS(PORTS)) u_lsta_checker (.*);

// File: verif/tb_learning_switch_table_with_aging.sv
module tb_learning_switch_table_with_aging;

    localparam int STATIONS    = 32;
    localparam int PORTS       = 8;
    localparam int ST_W        = lsta_pkg::ST_W;
    localparam int PT_W        = lsta_pkg::PT_W;
    localparam int AG_W        = lsta_pkg::AG_W;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_PAUSE = STATIONS + 8;
    localparam int DRAIN_BOUND = 4000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 22;

    typedef struct packed {
        logic             kind;
        logic [PORTS-1:0] mask;
        logic             known;
        logic [ST_W-1:0]  station;
        logic [PT_W-1:0]  port;
        logic             last;
    } fwd_beat_t;

    class station_table_sb;
        logic             live      [STATIONS];
        logic [PT_W-1:0]  seen_port [STATIONS];
        logic [AG_W-1:0]  age       [STATIONS];
        logic [AG_W-1:0]  aging;
        fwd_beat_t        expected_beats [$];
        int               errors;

        function new();
            aging  = lsta_pkg::AGING_RESET;
            errors = 0;
            for (int i = 0; i < STATIONS; i++)
            begin
                live[i]      = 1'b0;
                seen_port[i] = '0;
                age[i]       = '0;
            end
        endfunction

        function void set_aging(logic [AG_W-1:0] value);
            aging = value;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function logic [PORTS-1:0] port_onehot(logic [PT_W-1:0] p);
            logic [PORTS-1:0] bits;
            bits = '0;
            if (int'(p) < PORTS)
                bits[p] = 1'b1;
            return bits;
        endfunction

        function void note_command(logic m, logic [ST_W-1:0] s, logic [ST_W-1:0] d,
                                   logic [PT_W-1:0] p);
            fwd_beat_t beat;
            int        first;
            beat = '0;
            if (m == lsta_pkg::MODE_FRAME)
            begin
                if (int'(s) < STATIONS)
                begin
                    live[s]      = 1'b1;
                    seen_port[s] = p;
                    age[s]       = aging;
                end
                beat.kind = lsta_pkg::KIND_FWD;
                beat.last = 1'b1;
                if (int'(d) < STATIONS && live[d])
                begin
                    beat.known = 1'b1;
                    beat.mask  = port_onehot(seen_port[d]);
                end
                else
                    beat.mask = ~port_onehot(p);
                expected_beats.push_back(beat);
            end
            else
            begin
                first = expected_beats.size();
                for (int i = 0; i < STATIONS; i++)
                begin
                    if (live[i])
                    begin
                        if (age[i] <= 8'd1)
                        begin
                            age[i]       = '0;
                            live[i]      = 1'b0;
                            beat         = '0;
                            beat.kind    = lsta_pkg::KIND_EXP;
                            beat.station = ST_W'(i);
                            beat.port    = seen_port[i];
                            expected_beats.push_back(beat);
                        end
                        else
                            age[i] = age[i] - 8'd1;
                    end
                end
                if (expected_beats.size() > first)
                    expected_beats[expected_beats.size() - 1].last = 1'b1;
            end
        endfunction

        task report(string msg);
            if (errors < 50)
                $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_beat(logic k, logic [PORTS-1:0] m, logic w, logic [ST_W-1:0] st,
                        logic [PT_W-1:0] pt, logic l);
            fwd_beat_t got;
            fwd_beat_t want;
            got = {k, m, w, st, pt, l};
            if (expected_beats.size() == 0)
                report($sformatf("beat with nothing outstanding: %h", got));
            else
            begin
                want = expected_beats.pop_front();
                if (got !== want)
                    report($sformatf(
                        "kind %b/%b mask %h/%h known %b/%b st %0d/%0d pt %0d/%0d last %b/%b",
                        got.kind, want.kind, got.mask, want.mask, got.known, want.known,
                        got.station, want.station, got.port, want.port, got.last, want.last));
            end
        endtask

        task check_leftover();
            if (expected_beats.size() != 0)
                report($sformatf("%0d beats never arrived", expected_beats.size()));
        endtask
    endclass

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             start       = 1'b0;
    logic             mode        = lsta_pkg::MODE_FRAME;
    logic [ST_W-1:0]  src_station = '0;
    logic [ST_W-1:0]  dst_station = '0;
    logic [PT_W-1:0]  in_port     = '0;
    logic             psel        = 1'b0;
    logic             penable     = 1'b0;
    logic             pwrite      = 1'b0;
    logic [0:0]       paddr       = lsta_pkg::REG_AGING_START;
    logic [31:0]      pwdata      = '0;

    logic             busy;
    logic             strobe;
    logic             kind;
    logic [PORTS-1:0] port_mask;
    logic             was_known;
    logic [ST_W-1:0]  expired_station;
    logic [PT_W-1:0]  expired_port;
    logic             last;
    logic [31:0]      prdata;
    logic             pready;

    station_table_sb  table_sb;
    int               cycle_count = 0;
    logic [AG_W-1:0]  aging_plan [PHASES];
    logic             idle_on;

    learning_switch_table_with_aging #(
        .STATIONS (STATIONS),
        .PORTS    (PORTS)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .mode            (mode),
        .src_station     (src_station),
        .dst_station     (dst_station),
        .in_port         (in_port),
        .strobe          (strobe),
        .kind            (kind),
        .port_mask       (port_mask),
        .was_known       (was_known),
        .expired_station (expired_station),
        .expired_port    (expired_port),
        .last            (last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // check the outgoing beat before noting the new command at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe === 1'b1)
                table_sb.check_beat(kind, port_mask, was_known, expired_station,
                                    expired_port, last);
            if (start && busy === 1'b0)
                table_sb.note_command(mode, src_station, dst_station, in_port);
        end
    end

    task automatic send_cmd(input logic m, input logic [ST_W-1:0] s,
                            input logic [ST_W-1:0] d, input logic [PT_W-1:0] p);
        start       <= 1'b1;
        mode        <= m;
        src_station <= s;
        dst_station <= d;
        in_port     <= p;
        do @(posedge clk); while (busy !== 1'b0);
    endtask

    task automatic send_tick();
        send_cmd(lsta_pkg::MODE_TICK, ST_W'($urandom), ST_W'($urandom), PT_W'($urandom));
    endtask

    task automatic pause_cmd(input int cycles);
        start       <= 1'b0;
        mode        <= 1'($urandom);
        src_station <= ST_W'($urandom);
        dst_station <= ST_W'($urandom);
        in_port     <= PT_W'($urandom);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_results(input int bound);
        int waited;
        start  <= 1'b0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while ((table_sb.pending() != 0 || busy !== 1'b0) && waited < bound);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic program_aging(input logic [AG_W-1:0] value);
        logic [31:0] word;
        word    = {24'($urandom), value};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lsta_pkg::REG_AGING_START;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        table_sb.set_aging(value);
    endtask

    task automatic random_cmd(input int tick_pct);
        logic [ST_W-1:0] s;
        logic [ST_W-1:0] d;
        // favour a few stations so that lookups hit learned entries
        s = ($urandom_range(0, 1) == 0) ? ST_W'($urandom_range(0, 7)) : ST_W'($urandom);
        d = ($urandom_range(0, 1) == 0) ? ST_W'($urandom_range(0, 7)) : ST_W'($urandom);
        if ($urandom_range(0, 99) < tick_pct)
            send_tick();
        else
            send_cmd(lsta_pkg::MODE_FRAME, s, d, PT_W'($urandom));
    endtask

    initial
    begin
        table_sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        program_aging(lsta_pkg::AGING_RESET);

        send_cmd(lsta_pkg::MODE_FRAME, 5'd0, 5'd31, 3'd0);
        send_cmd(lsta_pkg::MODE_FRAME, 5'd31, 5'd0, 3'd7);
        send_cmd(lsta_pkg::MODE_FRAME, 5'd5, 5'd5, 3'd3);
        send_cmd(lsta_pkg::MODE_FRAME, 5'd6, 5'd31, 3'd2);
        for (int p = 0; p < 8; p++)
            send_cmd(lsta_pkg::MODE_FRAME, ST_W'(8 + p), ST_W'(16 + p), PT_W'(p));
        send_tick();

        drain_results(DRAIN_BOUND);
        program_aging(8'd1);
        send_cmd(lsta_pkg::MODE_FRAME, 5'd10, 5'd8, 3'd4);
        send_tick();

        drain_results(DRAIN_BOUND);
        program_aging(8'd0);
        send_cmd(lsta_pkg::MODE_FRAME, 5'd12, 5'd12, 3'd5);
        send_cmd(lsta_pkg::MODE_FRAME, 5'd13, 5'd30, 3'd6);
        send_tick();
        send_tick();

        drain_results(DRAIN_BOUND);
        program_aging(8'd255);
        send_cmd(lsta_pkg::MODE_FRAME, 5'd31, 5'd0, 3'd1);
        send_cmd(lsta_pkg::MODE_FRAME, 5'd0, 5'd31, 3'd7);

        aging_plan[0] = 8'd3;
        aging_plan[1] = 8'd255;
        aging_plan[2] = 8'd0;
        aging_plan[3] = 8'd1;
        aging_plan[4] = AG_W'($urandom_range(1, 255));
        aging_plan[5] = lsta_pkg::AGING_RESET;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results(DRAIN_BOUND);
            program_aging(aging_plan[ph]);
            // hold the sender steady in the closing phase
            idle_on = (ph != PHASES - 1);
            repeat (PHASE_ITEMS)
            begin
                random_cmd((aging_plan[ph] <= 8'd3) ? 35 : 20);
                if (idle_on && $urandom_range(0, 3) == 0)
                    pause_cmd($urandom_range(1, 16));
            end
        end

        drain_results(DRAIN_BOUND);
        table_sb.check_leftover();
        if (table_sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/lsta_pkg.sv
rtl/lsta_cell.sv
rtl/learning_switch_table_with_aging.sv
rtl/lsta_checker.sv
verif/tb_learning_switch_table_with_aging.sv
